// ----- design/slxfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slxfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    localparam int FIFO_DEPTH_DEF = 4;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 56;

    typedef enum logic [2:0] {
        PH_SYNC0 = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_CMD   = 3'd4,
        PH_PAY   = 3'd5,
        PH_CK    = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SYNC  = 2'd1,
        ST_SHORT = 2'd2,
        ST_CKSUM = 2'd3
    } status_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // One parsed input byte: a payload result, a verdict, or both
    typedef struct packed {
        logic        has_pay;
        logic        has_verdict;
        logic [7:0]  pay_byte;
        logic [15:0] pay_index;
        logic [7:0]  command;
        logic [15:0] length;
        status_t     status;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- design/sync_length_xor_frame_parser.sv -----
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Receive-side parser for AA 55 / length / command / payload / XOR frames.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                | tuser | tlast
//  s_      | in  | rx_byte[7:0]                                      |  -    | buffer_end
//  m_      | out | payload_byte, payload_index, command,             | kind  | last
//          |     | payload_length, status, 6 pad bits                |       |
//
// One byte is taken per cycle while the queue is not full. A byte that yields
// both a payload result and a verdict takes two output transfers; the event
// queue absorbs that and any back-pressure. Reset (aresetn, synchronous)
// clears parser and queue; s_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_parser
    import slxfp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // byte[7:0] index[23:8] cmd[31:24]
                                                  // length[47:32] status[49:48]
    output logic                       m_tuser,   // kind
    output logic                       m_tlast
);

    event_t     ev_in, ev_out;
    logic       push, pop, accept;
    fifo_stat_t fstat;

    assign s_tready = !fstat.full;
    assign accept   = s_tvalid && s_tready;

    slxfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .buffer_end (s_tlast),
        .ev         (ev_in),
        .push       (push)
    );

    slxfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (ev_in),
        .pop     (pop),
        .rd_data (ev_out),
        .stat    (fstat)
    );

    slxfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev_out),
        .ev_avail (!fstat.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_queue_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fstat.full && fstat.empty))
        else $error("queue reports full and empty together");

    a_verdict_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> m_tlast)
        else $error("verdict not marked last");

    a_payload_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[49:48] == ST_OK))
        else $error("payload result carries nonzero status");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fstat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/slxfp_front.sv -----
// ----------------------------------------------------------------------------
// slxfp_front
// Byte-level frame parser: tracks header, payload and checksum, and turns
// each accepted byte into at most one event for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_front
    import slxfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       buffer_end,
    output event_t          ev,
    output logic            push
);

    phase_t      phase_reg,  phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg,  count_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [7:0]  cmd_reg,    cmd_next;

    logic    verdict;
    logic    pay;
    logic    show_cmd;
    logic    show_len;
    status_t status;
    logic [7:0] expected;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC0;
            length_reg <= '0;
            count_reg  <= '0;
            xor_reg    <= '0;
            cmd_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            cmd_reg    <= cmd_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        cmd_next    = cmd_reg;
        verdict     = 1'b0;
        pay         = 1'b0;
        show_cmd    = 1'b0;
        show_len    = 1'b0;
        status      = ST_OK;
        expected    = (phase_reg == PH_SYNC0) ? SYNC_FIRST : SYNC_SECOND;

        unique case (phase_reg)
            PH_SYNC0, PH_SYNC1: begin
                if (rx_byte != expected) begin
                    verdict = 1'b1;
                    status  = ST_SYNC;
                end else begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = (phase_reg == PH_SYNC0) ? PH_SYNC1 : PH_LENHI;
                end
            end
            PH_LENHI: begin
                xor_next    = xor_reg ^ rx_byte;
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LENLO;
            end
            PH_LENLO: begin
                xor_next    = xor_reg ^ rx_byte;
                length_next = {length_reg[15:8], rx_byte};
                phase_next  = PH_CMD;
                show_len    = 1'b1;
            end
            PH_CMD: begin
                xor_next   = xor_reg ^ rx_byte;
                cmd_next   = rx_byte;
                phase_next = (length_reg == 16'd0) ? PH_CK : PH_PAY;
                show_len   = 1'b1;
                show_cmd   = 1'b1;
            end
            PH_PAY: begin
                xor_next   = xor_reg ^ rx_byte;
                pay        = 1'b1;
                count_next = count_reg + 16'd1;
                if (count_next == length_reg) begin
                    phase_next = PH_CK;
                end
                show_len   = 1'b1;
                show_cmd   = 1'b1;
            end
            PH_CK: begin
                verdict  = 1'b1;
                status   = (rx_byte == xor_reg) ? ST_OK : ST_CKSUM;
                show_len = 1'b1;
                show_cmd = 1'b1;
            end
            PH_DONE: begin
                show_len = 1'b1;
                show_cmd = 1'b1;
            end
            default: ;
        endcase

        // buffer ran out before the checksum byte
        if (!verdict && buffer_end && phase_reg != PH_CK && phase_reg != PH_DONE) begin
            verdict = 1'b1;
            status  = ST_SHORT;
        end
        if (verdict) begin
            phase_next = PH_DONE;
        end

        ev.has_pay     = pay;
        ev.has_verdict = verdict;
        ev.pay_byte    = rx_byte;
        ev.pay_index   = count_reg;
        ev.command     = show_cmd ? cmd_next : 8'h00;
        ev.length      = show_len ? length_next : 16'h0000;
        ev.status      = status;
        push           = accept && (pay || verdict);

        // every buffer starts a fresh frame
        if (buffer_end) begin
            phase_next  = PH_SYNC0;
            length_next = '0;
            count_next  = '0;
            xor_next    = '0;
            cmd_next    = '0;
        end
    end

endmodule

`default_nettype wire

// ----- design/slxfp_fifo.sv -----
// ----------------------------------------------------------------------------
// slxfp_fifo
// Small event queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_fifo
    import slxfp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire event_t wr_data,
    input  wire logic   pop,
    output event_t      rd_data,
    output fifo_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    event_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/slxfp_back.sv -----
// ----------------------------------------------------------------------------
// slxfp_back
// Result emitter: holds one event and sends its payload result and/or
// verdict on the master stream, one request per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_back
    import slxfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire event_t                ev,
    input  wire logic                  ev_avail,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    event_t cur_reg;
    logic   valid_reg, valid_next;
    logic   pay_sent_reg, pay_sent_next;
    logic   is_pay, take, finish, load;

    assign is_pay   = cur_reg.has_pay && !pay_sent_reg;
    assign m_tvalid = valid_reg;
    assign take     = valid_reg && m_tready;
    assign finish   = take && !(is_pay && cur_reg.has_verdict);
    assign load     = (!valid_reg || finish) && ev_avail;
    assign pop      = load;

    always_comb begin
        valid_next    = valid_reg;
        pay_sent_next = pay_sent_reg;
        if (load) begin
            valid_next    = 1'b1;
            pay_sent_next = 1'b0;
        end else if (finish) begin
            valid_next    = 1'b0;
        end else if (take) begin
            pay_sent_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            pay_sent_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            pay_sent_reg <= pay_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= ev;
        end
    end

    always_comb begin
        m_tuser = is_pay ? KIND_PAYLOAD : KIND_VERDICT;
        m_tlast = !(is_pay && cur_reg.has_verdict);
        if (is_pay) begin
            m_tdata = {6'b0, ST_OK, cur_reg.length, cur_reg.command,
                       cur_reg.pay_index, cur_reg.pay_byte};
        end else begin
            m_tdata = {6'b0, cur_reg.status, cur_reg.length, cur_reg.command,
                       16'h0000, 8'h00};
        end
    end

endmodule

`default_nettype wire
